FILE: hdl/msexu_pkg.sv
// shared types and constants for the mips subset execute unit
`timescale 1ns / 1ps

package msexu_pkg;

  // default sizing
  localparam int unsigned REG_COUNT_DEF  = 32;
  localparam int unsigned DATA_WORDS_DEF = 1024;
  localparam int unsigned INST_BYTES_DEF = 2048;
  localparam int unsigned WORD_BITS_DEF  = 32;

  // fixed field widths
  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned IMM_W     = 16;
  localparam int unsigned TGT_W     = 11;
  localparam int unsigned PC_OUT_W  = 11;
  localparam int unsigned CYC_W     = 32;
  localparam int unsigned WVAL_W    = 32;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned SHAMT_W   = 5;

  // cycle latencies per instruction class
  localparam logic [CYC_W-1:0] LAT_LOAD   = 32'd5;
  localparam logic [CYC_W-1:0] LAT_JUMP   = 32'd1;
  localparam logic [CYC_W-1:0] LAT_BRANCH = 32'd3;
  localparam logic [CYC_W-1:0] LAT_OTHER  = 32'd4;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_ADDI = 4'd2,
    OP_SUBI = 4'd3,
    OP_OR   = 4'd4,
    OP_AND  = 4'd5,
    OP_SLL  = 4'd6,
    OP_SRL  = 4'd7,
    OP_LW   = 4'd8,
    OP_SW   = 4'd9,
    OP_J    = 4'd10,
    OP_BEQ  = 4'd11,
    OP_BNE  = 4'd12,
    OP_SLT  = 4'd13
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SINGLE = 2'd0,
    MODE_MULTI  = 2'd1,
    MODE_PIPE   = 2'd2
  } mode_e;

endpackage

FILE: hdl/msexu_regfile.sv
// register file: two synchronous read ports, one write port, write-first bypass
`timescale 1ns / 1ps

module msexu_regfile #(
  parameter int unsigned REG_COUNT = msexu_pkg::REG_COUNT_DEF,
  parameter int unsigned WORD_BITS = msexu_pkg::WORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               re_i,
  input  logic [msexu_pkg::REG_IDX_W-1:0]    raddr_a_i,
  input  logic [msexu_pkg::REG_IDX_W-1:0]    raddr_b_i,
  output logic [WORD_BITS-1:0]               rdata_a_o,
  output logic [WORD_BITS-1:0]               rdata_b_o,
  input  logic                               we_i,
  input  logic [msexu_pkg::REG_IDX_W-1:0]    waddr_i,
  input  logic [WORD_BITS-1:0]               wdata_i
);

  localparam int unsigned RIW = $clog2(REG_COUNT);
  localparam int unsigned CW  = msexu_pkg::REG_IDX_W + 1;

  logic [WORD_BITS-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [WORD_BITS-1:0] rdata_a_q, rdata_b_q;
  logic                 ok_a, ok_b, hit_a, hit_b;

  // register zero and indexes past the file read as zero
  assign ok_a  = (raddr_a_i != '0) && (CW'(raddr_a_i) < CW'(REG_COUNT));
  assign ok_b  = (raddr_b_i != '0) && (CW'(raddr_b_i) < CW'(REG_COUNT));
  assign hit_a = we_i && (waddr_i == raddr_a_i);
  assign hit_b = we_i && (waddr_i == raddr_b_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i[RIW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i[RIW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (!ok_a) begin
        rdata_a_q <= '0;
      end else if (hit_a) begin
        rdata_a_q <= wdata_i;
      end else if (!vld_q[raddr_a_i[RIW-1:0]]) begin
        rdata_a_q <= '0;
      end else begin
        rdata_a_q <= mem[raddr_a_i[RIW-1:0]];
      end
      if (!ok_b) begin
        rdata_b_q <= '0;
      end else if (hit_b) begin
        rdata_b_q <= wdata_i;
      end else if (!vld_q[raddr_b_i[RIW-1:0]]) begin
        rdata_b_q <= '0;
      end else begin
        rdata_b_q <= mem[raddr_b_i[RIW-1:0]];
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hdl/msexu_dmem.sv
// data memory: single port, registered read, clearing sweep after reset
`timescale 1ns / 1ps

module msexu_dmem #(
  parameter int unsigned DATA_WORDS = msexu_pkg::DATA_WORDS_DEF,
  parameter int unsigned WORD_BITS  = msexu_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          we_i,
  input  logic [$clog2(DATA_WORDS)-1:0] addr_i,
  input  logic [WORD_BITS-1:0]          wdata_i,
  output logic [WORD_BITS-1:0]          rdata_o,
  output logic                          busy_o
);

  localparam int unsigned AW = $clog2(DATA_WORDS);

  logic [WORD_BITS-1:0] mem [DATA_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 clr_q;
  logic [AW-1:0]        clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(DATA_WORDS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (en_i && !we_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule

FILE: hdl/mips_subset_execute_unit_top.sv
// top level of the mips subset execute unit: pipeline control and execute logic
//
//  channel | dir | handshake                        | payload
//  --------+-----+----------------------------------+-----------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready    | tuser opcode, tdata operand fields
//  m_axis  | out | m_axis_tvalid / m_axis_tready    | tdata result fields
//  cfg     | in  | cfg_valid_i / cfg_ready_o        | cfg_data_i datapath_mode
//
// one instruction per cycle unless m_axis stalls; a beat enters the output register after
// acceptance (register file read at the accepting edge, execute, data memory read / writeback)
// back pressure on m_axis fills the stage registers one by one before s_axis_tready drops
// after reset the data memory is swept to zero word by word with s_axis_tready low
// register writes land at the end of the memory stage; the stage before is bypassed from it
`timescale 1ns / 1ps

module mips_subset_execute_unit_top #(
  parameter int unsigned REG_COUNT        = msexu_pkg::REG_COUNT_DEF,
  parameter int unsigned DATA_WORDS       = msexu_pkg::DATA_WORDS_DEF,
  parameter int unsigned INST_SPACE_BYTES = msexu_pkg::INST_BYTES_DEF,
  parameter int unsigned WORD_BITS        = msexu_pkg::WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input instruction stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] dest_reg, [9:5] src_reg, [14:10] second_reg, [30:15] immediate,
  // [41:31] target_address, [42] target_valid, [47:43] zero
  input  logic [47:0] s_axis_tdata,
  // [3:0] opcode
  input  logic [3:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [10:0] next_pc, [42:11] cycle_total, [43] write_enable, [48:44] write_index,
  // [80:49] write_value, [81] branch_taken, [87:82] zero
  output logic [87:0] m_axis_tdata,
  // datapath mode register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  localparam int unsigned RW   = msexu_pkg::REG_IDX_W;
  localparam int unsigned AW   = $clog2(DATA_WORDS);
  localparam int unsigned PCW  = $clog2(INST_SPACE_BYTES);
  localparam int unsigned TW   = 21;   // holds INST_SPACE_BYTES shifted by four
  localparam int unsigned CYCW = msexu_pkg::CYC_W;

  // ---------------------------------------------------------------------------
  // input unpack
  // ---------------------------------------------------------------------------
  msexu_pkg::op_e                  in_op;
  logic [RW-1:0]                   in_rd, in_rs, in_rt;
  logic [msexu_pkg::IMM_W-1:0]     in_imm;
  logic [msexu_pkg::TGT_W-1:0]     in_tgt;
  logic                            in_tv;
  logic                            in_acc;
  logic [RW-1:0]                   in_aidx, in_bidx;

  assign in_op  = msexu_pkg::op_e'(s_axis_tuser);
  assign in_rd  = s_axis_tdata[4:0];
  assign in_rs  = s_axis_tdata[9:5];
  assign in_rt  = s_axis_tdata[14:10];
  assign in_imm = s_axis_tdata[30:15];
  assign in_tgt = s_axis_tdata[41:31];
  assign in_tv  = s_axis_tdata[42];

  // port a: first source, or store data for sw
  // port b: second source / base, or first compare register for branches
  assign in_aidx = (in_op == msexu_pkg::OP_SW) ? in_rd : in_rs;
  assign in_bidx = ((in_op == msexu_pkg::OP_BEQ) || (in_op == msexu_pkg::OP_BNE)) ?
                   in_rd : in_rt;

  // ---------------------------------------------------------------------------
  // state and stage registers
  // ---------------------------------------------------------------------------
  logic [msexu_pkg::MODE_W-1:0] mode_q;
  logic [PCW-1:0]               pc_q, pc_d;
  logic [CYCW-1:0]              cyc_q, cyc_d;

  // execute stage (register file data arrives here)
  logic                         s1_v_q;
  msexu_pkg::op_e               s1_op_q;
  logic [RW-1:0]                s1_rd_q, s1_aidx_q, s1_bidx_q;
  logic [msexu_pkg::IMM_W-1:0]  s1_imm_q;
  logic [msexu_pkg::TGT_W-1:0]  s1_tgt_q;
  logic                         s1_tv_q;

  // memory / writeback stage
  logic                         s2_v_q;
  logic                         s2_we_q, s2_we_d;
  logic [RW-1:0]                s2_widx_q;
  logic                         s2_lw_q;
  logic [WORD_BITS-1:0]         s2_val_q, s2_val_d;
  logic [PCW-1:0]               s2_pc_q;
  logic [CYCW-1:0]              s2_cyc_q;
  logic                         s2_taken_q, s2_taken_d;

  // output register
  logic                         out_v_q;
  logic [87:0]                  out_data_q, out_data_d;

  // handshake between stages
  logic s2_adv, s2_free, s1_move, clr_busy;

  assign s2_adv  = s2_v_q && (!out_v_q || m_axis_tready);
  assign s2_free = !s2_v_q || s2_adv;
  assign s1_move = s1_v_q && s2_free;

  assign s_axis_tready = !clr_busy && (!s1_v_q || s2_free);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0] rf_rdata_a, rf_rdata_b, s2_wv;
  logic                 rf_we;
  logic                 dm_en, dm_we;
  logic [AW-1:0]        dm_addr;
  logic [WORD_BITS-1:0] dm_wdata, dm_rdata;

  // value that the writeback stage commits
  assign s2_wv = s2_lw_q ? dm_rdata : s2_val_q;
  assign rf_we = s2_adv && s2_we_q;

  msexu_regfile #(
    .REG_COUNT (REG_COUNT),
    .WORD_BITS (WORD_BITS)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (in_acc),
    .raddr_a_i (in_aidx),
    .raddr_b_i (in_bidx),
    .rdata_a_o (rf_rdata_a),
    .rdata_b_o (rf_rdata_b),
    .we_i      (rf_we),
    .waddr_i   (s2_widx_q),
    .wdata_i   (s2_wv)
  );

  msexu_dmem #(
    .DATA_WORDS (DATA_WORDS),
    .WORD_BITS  (WORD_BITS)
  ) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (dm_en),
    .we_i    (dm_we),
    .addr_i  (dm_addr),
    .wdata_i (dm_wdata),
    .rdata_o (dm_rdata),
    .busy_o  (clr_busy)
  );

  // ---------------------------------------------------------------------------
  // execute
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0]         opa, opb, imm_w, maddr;
  logic [msexu_pkg::SHAMT_W-1:0] shamt;
  logic [PCW:0]                 pc_inc;
  logic [TW-1:0]                tgt_red;
  logic [CYCW-1:0]              lat;
  logic                         lat_ok;
  logic                         wr_op;

  always_comb begin
    // bypass from the writeback stage, which has not committed yet
    opa = (s2_v_q && s2_we_q && (s2_widx_q == s1_aidx_q)) ? s2_wv : rf_rdata_a;
    opb = (s2_v_q && s2_we_q && (s2_widx_q == s1_bidx_q)) ? s2_wv : rf_rdata_b;

    imm_w = WORD_BITS'($signed(s1_imm_q));
    shamt = s1_imm_q[msexu_pkg::SHAMT_W-1:0];
    maddr = opb + imm_w;

    s2_val_d   = '0;
    s2_taken_d = 1'b0;
    wr_op      = 1'b0;
    lat        = msexu_pkg::LAT_OTHER;
    lat_ok     = 1'b1;
    case (s1_op_q)
      msexu_pkg::OP_ADD: begin
        s2_val_d = opa + opb;
        wr_op    = 1'b1;
      end
      msexu_pkg::OP_SUB: begin
        s2_val_d = opa - opb;
        wr_op    = 1'b1;
      end
      msexu_pkg::OP_ADDI: begin
        s2_val_d = opa + imm_w;
        wr_op    = 1'b1;
      end
      msexu_pkg::OP_SUBI: begin
        s2_val_d = opa - imm_w;
        wr_op    = 1'b1;
      end
      msexu_pkg::OP_OR: begin
        s2_val_d = opa | opb;
        wr_op    = 1'b1;
      end
      msexu_pkg::OP_AND: begin
        s2_val_d = opa & opb;
        wr_op    = 1'b1;
      end
      msexu_pkg::OP_SLL: begin
        s2_val_d = opa << shamt;
        wr_op    = 1'b1;
      end
      msexu_pkg::OP_SRL: begin
        s2_val_d = opa >> shamt;
        wr_op    = 1'b1;
      end
      msexu_pkg::OP_LW: begin
        wr_op = 1'b1;
        lat   = msexu_pkg::LAT_LOAD;
      end
      msexu_pkg::OP_SW: begin
        lat = msexu_pkg::LAT_OTHER;
      end
      msexu_pkg::OP_J: begin
        s2_taken_d = s1_tv_q;
        lat        = msexu_pkg::LAT_JUMP;
      end
      msexu_pkg::OP_BEQ: begin
        s2_taken_d = s1_tv_q && (opb == opa);
        lat        = msexu_pkg::LAT_BRANCH;
      end
      msexu_pkg::OP_BNE: begin
        s2_taken_d = s1_tv_q && (opb != opa);
        lat        = msexu_pkg::LAT_BRANCH;
      end
      msexu_pkg::OP_SLT: begin
        s2_val_d = ($signed(opa) < $signed(opb)) ? WORD_BITS'(1) : '0;
        wr_op    = 1'b1;
      end
      default: begin
        // undefined opcode: pc still advances, count untouched
        lat_ok = 1'b0;
      end
    endcase

    // writes to register zero or past the file are dropped and not reported
    s2_we_d = wr_op && (s1_rd_q != '0) && ((RW + 1)'(s1_rd_q) < (RW + 1)'(REG_COUNT));

    // sequential pc, wrapped at the instruction space
    pc_inc = (PCW + 1)'(pc_q) + (PCW + 1)'(4);
    if (pc_inc >= (PCW + 1)'(INST_SPACE_BYTES)) begin
      pc_inc = pc_inc - (PCW + 1)'(INST_SPACE_BYTES);
    end

    // word-aligned target reduced into the instruction space
    tgt_red = TW'({s1_tgt_q[msexu_pkg::TGT_W-1:2], 2'b00});
    for (int k = 4; k >= 0; k--) begin
      if (tgt_red >= (TW'(INST_SPACE_BYTES) << k)) begin
        tgt_red = tgt_red - (TW'(INST_SPACE_BYTES) << k);
      end
    end

    pc_d = s2_taken_d ? tgt_red[PCW-1:0] : pc_inc[PCW-1:0];

    // cycle accounting
    cyc_d = cyc_q;
    if (lat_ok) begin
      case (msexu_pkg::mode_e'(mode_q))
        msexu_pkg::MODE_SINGLE: cyc_d = cyc_q + 1'b1;
        msexu_pkg::MODE_MULTI:  cyc_d = cyc_q + lat;
        msexu_pkg::MODE_PIPE:   cyc_d = (cyc_q == '0) ? lat : cyc_q + 1'b1;
        default:                cyc_d = cyc_q;
      endcase
    end
  end

  // data memory access happens as the instruction leaves execute
  assign dm_en    = s1_move && ((s1_op_q == msexu_pkg::OP_LW) ||
                                (s1_op_q == msexu_pkg::OP_SW));
  assign dm_we    = (s1_op_q == msexu_pkg::OP_SW);
  assign dm_addr  = maddr[AW-1:0];
  assign dm_wdata = opa;

  // ---------------------------------------------------------------------------
  // output pack
  // ---------------------------------------------------------------------------
  logic [63:0] wv_ext;

  always_comb begin
    wv_ext     = 64'(s2_wv);
    out_data_d = '0;
    out_data_d[10:0]  = msexu_pkg::PC_OUT_W'(s2_pc_q);
    out_data_d[42:11] = s2_cyc_q;
    out_data_d[43]    = s2_we_q;
    out_data_d[48:44] = s2_we_q ? s2_widx_q : '0;
    out_data_d[80:49] = s2_we_q ? wv_ext[msexu_pkg::WVAL_W-1:0] : '0;
    out_data_d[81]    = s2_taken_q;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      pc_q    <= '0;
      cyc_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (s1_move) begin
        pc_q  <= pc_d;
        cyc_q <= cyc_d;
      end
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= in_op;
      s1_rd_q   <= in_rd;
      s1_aidx_q <= in_aidx;
      s1_bidx_q <= in_bidx;
      s1_imm_q  <= in_imm;
      s1_tgt_q  <= in_tgt;
      s1_tv_q   <= in_tv;
    end
    if (s1_move) begin
      s2_we_q    <= s2_we_d;
      s2_widx_q  <= s1_rd_q;
      s2_lw_q    <= (s1_op_q == msexu_pkg::OP_LW);
      s2_val_q   <= s2_val_d;
      s2_pc_q    <= pc_d;
      s2_cyc_q   <= cyc_d;
      s2_taken_q <= s2_taken_d;
    end
    if (s2_adv) begin
      out_data_q <= out_data_d;
    end
  end

endmodule
